/* rtl/wsip_pkg.sv */
// ----------------------------------------------------------------------------
// wsip_pkg
// Shared types, register map and constants for the wide string integer parser
// ----------------------------------------------------------------------------
package wsip_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CHAR_BITS     = 32;
    localparam int BASE_BITS     = 6;
    localparam int VALUE_BITS    = 64;
    localparam int STATUS_BITS   = 2;
    localparam int CONSUMED_BITS = 16;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // register indexes
    localparam logic [1:0] REG_NUMBER_BASE   = 2'd0;
    localparam logic [1:0] REG_RESULT_WIDE   = 2'd1;
    localparam logic [1:0] REG_RESULT_SIGNED = 2'd2;

    localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NODIGITS = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_BADBASE  = 2'd3;

    // classified character
    typedef struct packed {
        logic                 is_nul;
        logic                 is_ws;
        logic                 is_plus;
        logic                 is_minus;
        logic                 is_zero;
        logic                 is_x;
        logic                 is_alnum;
        logic [BASE_BITS-1:0] dval;
        logic                 last;
    } item_t;

    // end-of-string state handed to the formatter
    typedef struct packed {
        logic                     invalid;
        logic                     digit_seen;
        logic                     negative;
        logic                     overflowed;
        logic [VALUE_BITS-1:0]    accumulator;
        logic [CONSUMED_BITS-1:0] consumed;
    } snap_t;

endpackage

/* rtl/wide_string_integer_parser.sv */
// ----------------------------------------------------------------------------
// wide_string_integer_parser
// Streaming string-to-integer converter with base detection and clamping
//
//   channel | ports                                        | role
//   --------+----------------------------------------------+-----------------
//   s_      | s_valid s_ready s_character s_end_of_string  | one char per item
//   m_      | m_valid m_ready m_value m_status m_consumed  | one item per string
//   apb     | psel penable pwrite paddr pwdata prdata      | base, width, sign
//
// one character per cycle sustained while the result side does not back up;
// the parse engine does its multiply-add combinationally
// m_valid rises once the last character of a string has passed the input
// register, queue, engine snapshot and output register
// reset is synchronous active low; no clearing pass
// with m_ready low two results wait in the snapshot and output registers; the
// next string end then holds at the head of the queue and the input backs up
// ----------------------------------------------------------------------------
module wide_string_integer_parser import wsip_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CHAR_BITS-1:0]     s_character,
    input  logic                     s_end_of_string,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [VALUE_BITS-1:0]    m_value,
    output logic [STATUS_BITS-1:0]   m_status,
    output logic [CONSUMED_BITS-1:0] m_consumed
);

    logic [BASE_BITS-1:0] base_reg;
    logic                 wide_reg;
    logic                 signed_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    logic        push;
    item_t       push_item;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    logic [$bits(item_t)-1:0] q_data;
    item_t       q_item;
    logic        snap_load;
    snap_t       snap;
    logic        snap_free;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign q_item  = item_t'(q_data);

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_NUMBER_BASE:   prdata = APB_DATA_BITS'(base_reg);
            REG_RESULT_WIDE:   prdata = APB_DATA_BITS'(wide_reg);
            REG_RESULT_SIGNED: prdata = APB_DATA_BITS'(signed_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= BASE_RESET;
            wide_reg   <= 1'b1;
            signed_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NUMBER_BASE:   base_reg   <= pwdata[BASE_BITS-1:0];
                REG_RESULT_WIDE:   wide_reg   <= pwdata[0];
                REG_RESULT_SIGNED: signed_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    wsip_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_character     (s_character),
        .s_end_of_string (s_end_of_string),
        .push            (push),
        .push_item       (push_item),
        .q_full          (q_full)
    );

    wsip_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    wsip_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .number_base (base_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .pop         (q_pop),
        .snap_load   (snap_load),
        .snap        (snap),
        .snap_free   (snap_free)
    );

    wsip_format u_format (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .result_wide   (wide_reg),
        .result_signed (signed_reg),
        .snap_load     (snap_load),
        .snap_in       (snap),
        .snap_free     (snap_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_status      (m_status),
        .m_consumed    (m_consumed)
    );

endmodule

/* rtl/wsip_front.sv */
// ----------------------------------------------------------------------------
// wsip_front
// Input stage: registers each item and classifies the character
// ----------------------------------------------------------------------------
module wsip_front import wsip_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAR_BITS-1:0] s_character,
    input  logic                 s_end_of_string,
    output logic                 push,
    output item_t                push_item,
    input  logic                 q_full
);

    logic  f_valid_reg;
    logic  f_valid_next;
    item_t f_item_reg;
    item_t cls;

    assign push      = f_valid_reg && !q_full;
    assign s_ready   = !f_valid_reg || !q_full;
    assign push_item = f_item_reg;

    always_comb begin
        cls          = '0;
        cls.last     = s_end_of_string;
        cls.is_nul   = (s_character == 32'd0);
        cls.is_ws    = (s_character == 32'd32) ||
                       (s_character >= 32'd9 && s_character <= 32'd13);
        cls.is_plus  = (s_character == 32'd43);
        cls.is_minus = (s_character == 32'd45);
        cls.is_zero  = (s_character == 32'd48);
        cls.is_x     = (s_character == 32'd120) || (s_character == 32'd88);
        if (s_character >= 32'd48 && s_character <= 32'd57) begin
            cls.is_alnum = 1'b1;
            cls.dval     = BASE_BITS'(s_character - 32'd48);
        end else if (s_character >= 32'd97 && s_character <= 32'd122) begin
            cls.is_alnum = 1'b1;
            cls.dval     = BASE_BITS'(s_character - 32'd87);
        end else if (s_character >= 32'd65 && s_character <= 32'd90) begin
            cls.is_alnum = 1'b1;
            cls.dval     = BASE_BITS'(s_character - 32'd55);
        end
    end

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_valid && s_ready) begin
            f_valid_next = 1'b1;
        end else if (push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            f_item_reg <= cls;
        end
    end

endmodule

/* rtl/wsip_queue.sv */
// ----------------------------------------------------------------------------
// wsip_queue
// Short first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
module wsip_queue import wsip_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [ADDR_BITS:0] wr_ptr_reg;
    logic [ADDR_BITS:0] rd_ptr_reg;

    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign full      = (wr_ptr_reg[ADDR_BITS] != rd_ptr_reg[ADDR_BITS]) &&
                       (wr_ptr_reg[ADDR_BITS-1:0] == rd_ptr_reg[ADDR_BITS-1:0]);
    assign pop_data  = mem_reg[rd_ptr_reg[ADDR_BITS-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg[ADDR_BITS-1:0]] <= push_data;
        end
    end

endmodule

/* rtl/wsip_back.sv */
// ----------------------------------------------------------------------------
// wsip_back
// Parse engine: prefix and sign handling, base detection, digit accumulation
// ----------------------------------------------------------------------------
module wsip_back import wsip_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [BASE_BITS-1:0] number_base,
    input  logic                 q_not_empty,
    input  item_t                q_item,
    output logic                 pop,
    output logic                 snap_load,
    output snap_t                snap,
    input  logic                 snap_free
);

    localparam logic [2:0] PH_WS      = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_ZERO    = 3'd2;
    localparam logic [2:0] PH_ZEROX   = 3'd3;
    localparam logic [2:0] PH_DIGITS  = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_INVALID = 3'd6;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [2:0]               phase_reg,      phase_next;
    logic                     negative_reg,   negative_next;
    logic [BASE_BITS-1:0]     base_reg,       base_next;
    logic [VALUE_BITS-1:0]    acc_reg,        acc_next;
    logic                     seen_reg,       seen_next;
    logic                     ovf_reg,        ovf_next;
    logic [POSITION_BITS-1:0] pos_reg,        pos_next;
    logic [POSITION_BITS-1:0] end_reg,        end_next;

    logic                     first;
    logic [2:0]               ph0;
    logic [BASE_BITS-1:0]     ab0;
    logic [BASE_BITS-1:0]     dig_base;
    logic                     try_dig;
    logic                     is_dig;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [VALUE_BITS+6:0]    sum;
    logic                     emit;
    logic [31:0]              end_ext;

    assign first   = (phase_reg == PH_WS) && (pos_reg == '0);
    assign ab0     = first ? number_base : base_reg;
    assign ph0     = (first && (number_base == BASE_ONE || number_base > BASE_MAX))
                     ? PH_INVALID : phase_reg;
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign is_dig  = q_item.is_alnum && (q_item.dval < dig_base);
    assign sum     = (VALUE_BITS + 7)'(acc_reg) * (VALUE_BITS + 7)'(dig_base)
                     + (VALUE_BITS + 7)'(q_item.dval);
    assign emit    = q_item.is_nul || q_item.last;
    assign pop     = q_not_empty && (!emit || snap_free);
    assign snap_load = pop && emit;

    always_comb begin
        phase_next    = ph0;
        negative_next = negative_reg;
        base_next     = ab0;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        dig_base      = ab0;
        try_dig       = 1'b0;
        if (!q_item.is_nul) begin
            pos_next = pos_inc;
            unique case (ph0)
                PH_WS, PH_START: begin
                    if (ph0 == PH_WS && q_item.is_ws) begin
                        phase_next = PH_WS;
                    end else if (ph0 == PH_WS && (q_item.is_plus || q_item.is_minus)) begin
                        negative_next = q_item.is_minus;
                        phase_next    = PH_START;
                    end else if (q_item.is_zero && (ab0 == BASE_AUTO || ab0 == BASE_HEX)) begin
                        seen_next  = 1'b1;
                        acc_next   = '0;
                        end_next   = pos_inc;
                        phase_next = PH_ZERO;
                    end else begin
                        if (ab0 == BASE_AUTO) begin
                            base_next = BASE_DEC;
                            dig_base  = BASE_DEC;
                        end
                        try_dig = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (q_item.is_x) begin
                        base_next  = BASE_HEX;
                        phase_next = PH_ZEROX;
                    end else begin
                        if (ab0 == BASE_AUTO) begin
                            base_next = BASE_OCT;
                            dig_base  = BASE_OCT;
                        end
                        try_dig = 1'b1;
                    end
                end
                PH_ZEROX: begin
                    dig_base = BASE_HEX;
                    try_dig  = 1'b1;
                end
                PH_DIGITS: begin
                    try_dig = 1'b1;
                end
                PH_DONE, PH_INVALID: begin
                    phase_next = ph0;
                end
                default: begin
                    phase_next = ph0;
                end
            endcase
            if (try_dig) begin
                if (is_dig) begin
                    phase_next = PH_DIGITS;
                    seen_next  = 1'b1;
                    end_next   = pos_inc;
                    if (!ovf_reg) begin
                        if (sum[VALUE_BITS+6:VALUE_BITS] != '0) begin
                            acc_next = '1;
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = sum[VALUE_BITS-1:0];
                        end
                    end
                end else begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_comb begin
        end_ext          = 32'(end_next);
        snap.invalid     = (phase_next == PH_INVALID);
        snap.digit_seen  = seen_next;
        snap.negative    = negative_next;
        snap.overflowed  = ovf_next;
        snap.accumulator = acc_next;
        snap.consumed    = (end_ext > 32'hFFFF) ? '1 : end_ext[CONSUMED_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WS;
            negative_reg <= 1'b0;
            base_reg     <= '0;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            end_reg      <= '0;
        end else if (pop) begin
            if (emit) begin
                phase_reg    <= PH_WS;
                negative_reg <= 1'b0;
                base_reg     <= '0;
                acc_reg      <= '0;
                seen_reg     <= 1'b0;
                ovf_reg      <= 1'b0;
                pos_reg      <= '0;
                end_reg      <= '0;
            end else begin
                phase_reg    <= phase_next;
                negative_reg <= negative_next;
                base_reg     <= base_next;
                acc_reg      <= acc_next;
                seen_reg     <= seen_next;
                ovf_reg      <= ovf_next;
                pos_reg      <= pos_next;
                end_reg      <= end_next;
            end
        end
    end

endmodule

/* rtl/wsip_format.sv */
// ----------------------------------------------------------------------------
// wsip_format
// Result stage: clamps the magnitude to the selected width and sign mode
// ----------------------------------------------------------------------------
module wsip_format import wsip_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     result_wide,
    input  logic                     result_signed,
    input  logic                     snap_load,
    input  snap_t                    snap_in,
    output logic                     snap_free,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [VALUE_BITS-1:0]    m_value,
    output logic [STATUS_BITS-1:0]   m_status,
    output logic [CONSUMED_BITS-1:0] m_consumed
);

    logic                     sv_reg;
    snap_t                    s_reg;
    logic                     mv_reg;
    logic [VALUE_BITS-1:0]    val_reg,  val_next;
    logic [STATUS_BITS-1:0]   st_reg,   st_next;
    logic [CONSUMED_BITS-1:0] used_reg, used_next;
    logic                     out_load;
    logic [VALUE_BITS-1:0]    wmax;
    logic [VALUE_BITS-1:0]    half;
    logic [VALUE_BITS-1:0]    negm;
    logic                     ovf;

    assign out_load  = sv_reg && (!mv_reg || m_ready);
    assign snap_free = !sv_reg || out_load;
    assign m_valid    = mv_reg;
    assign m_value    = val_reg;
    assign m_status   = st_reg;
    assign m_consumed = used_reg;

    always_comb begin
        wmax      = result_wide ? '1 : {32'd0, 32'hFFFF_FFFF};
        half      = result_wide ? {1'b1, 63'd0} : {32'd0, 32'h8000_0000};
        negm      = (VALUE_BITS'(0) - s_reg.accumulator) & wmax;
        ovf       = s_reg.overflowed || (s_reg.accumulator > wmax);
        val_next  = '0;
        st_next   = ST_OK;
        used_next = '0;
        if (s_reg.invalid) begin
            st_next = ST_BADBASE;
        end else if (!s_reg.digit_seen) begin
            st_next = ST_NODIGITS;
        end else begin
            used_next = s_reg.consumed;
            if (!result_signed) begin
                if (ovf) begin
                    val_next = wmax;
                    st_next  = ST_RANGE;
                end else begin
                    val_next = s_reg.negative ? negm : s_reg.accumulator;
                end
            end else if (ovf) begin
                val_next = s_reg.negative ? half : half - 1'b1;
                st_next  = ST_RANGE;
            end else if (s_reg.negative) begin
                if (s_reg.accumulator > half) begin
                    val_next = half;
                    st_next  = ST_RANGE;
                end else begin
                    val_next = negm;
                end
            end else begin
                if (s_reg.accumulator > half - 1'b1) begin
                    val_next = half - 1'b1;
                    st_next  = ST_RANGE;
                end else begin
                    val_next = s_reg.accumulator;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (snap_load) begin
                sv_reg <= 1'b1;
            end else if (out_load) begin
                sv_reg <= 1'b0;
            end
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_load) begin
            s_reg <= snap_in;
        end
        if (out_load) begin
            val_reg  <= val_next;
            st_reg   <= st_next;
            used_reg <= used_next;
        end
    end

endmodule
